### design/cmf_pkg.sv
`default_nettype none

package cmf_pkg;

  localparam int CMF_MAX_WIDTH  = 1024;
  localparam int CMF_MAX_RADIUS = 2;
  localparam int PIXEL_BITS     = 8;

  localparam int COL_BITS      = 11;
  localparam int ROW_BITS      = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [COL_BITS-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [ROW_BITS-1:0] HEIGHT_RESET = 16'd480;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_RADIUS_SELECT = 2'd2,
    REG_FILTER_MODE   = 2'd3
  } cmf_reg_e;

  // control from the pixel pipeline to the window unit
  typedef struct packed {
    logic shift;
    logic radius2;
    logic take_max;
  } cmf_ctrl_t;

  function automatic pix_t pick_px(input pix_t a, input pix_t b, input logic take_max);
    pix_t res;
    if (take_max) begin
      res = (b > a) ? b : a;
    end else begin
      res = (b < a) ? b : a;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### design/cmf_ram.sv
`default_nettype none

module cmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/cmf_window.sv
`default_nettype none

module cmf_window #(
  parameter int MAX_RADIUS = cmf_pkg::CMF_MAX_RADIUS
) (
  input  wire logic                                           clk_i,
  input  wire cmf_pkg::cmf_ctrl_t                             ctrl_i,
  input  wire logic [2*MAX_RADIUS:0][cmf_pkg::PIXEL_BITS-1:0] newcol_i,
  output cmf_pkg::pix_t                                       result_o
);

  import cmf_pkg::*;

  localparam int WIN = 2 * MAX_RADIUS + 1;
  localparam int IW  = $clog2(WIN);

  pix_t taps_q  [WIN][WIN];
  pix_t shifted [WIN][WIN];

  logic [IW-1:0] ctr;
  pix_t          acc_v;
  pix_t          acc_h;

  // window slides left, new column enters on the right
  always_comb begin
    for (int y = 0; y < WIN; y++) begin
      for (int x = 0; x < WIN - 1; x++) begin
        shifted[y][x] = taps_q[y][x+1];
      end
      shifted[y][WIN-1] = newcol_i[y];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      taps_q <= shifted;
    end
  end

  // cross centre sits r columns and rows in from the newest corner
  always_comb begin
    ctr   = ctrl_i.radius2 ? IW'(WIN - 3) : IW'(WIN - 2);
    acc_v = shifted[ctr][ctr];
    acc_h = shifted[ctr][ctr];
    for (int k = 0; k < WIN; k++) begin
      if (ctrl_i.radius2 ? (k >= WIN - 5) : (k >= WIN - 3)) begin
        acc_v = pick_px(acc_v, shifted[k][ctr], ctrl_i.take_max);
        acc_h = pick_px(acc_h, shifted[ctr][k], ctrl_i.take_max);
      end
    end
    result_o = pick_px(acc_v, acc_h, ctrl_i.take_max);
  end

endmodule

`default_nettype wire

### design/cross_morphology_filter_core.sv
// an accepted request passes through the pixel stage and then the output register
// throughput: one pixel per cycle; the input stalls only while the pixel stage
//   is full and the output register is held by the consumer
// the line store takes one read and one write per cycle, which sets that rate
// reset: raster counters cleared, registers back to 640x480, radius 1, minimum;
//   the line store is not cleared
`default_nettype none

module cross_morphology_filter_core #(
  parameter int MAX_WIDTH  = cmf_pkg::CMF_MAX_WIDTH,
  parameter int MAX_RADIUS = cmf_pkg::CMF_MAX_RADIUS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [cmf_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [cmf_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire cmf_pkg::pix_t                     pixel_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output cmf_pkg::pix_t                          filtered_pixel_o,
  output logic                                   frame_last_o
);

  import cmf_pkg::*;

  localparam int WIN   = 2 * MAX_RADIUS + 1;
  localparam int LINES = 2 * MAX_RADIUS;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int LW    = LINES * PIXEL_BITS;
  localparam logic [COL_BITS-1:0] WIDTH_CAP = (MAX_WIDTH > 2047) ? 11'd2047 :
                                                                   11'(MAX_WIDTH);
  localparam logic [COL_BITS-1:0] ADDR_CAP  = (MAX_WIDTH > 2048) ? 11'd2047 :
                                                                   11'(MAX_WIDTH - 1);

  // configuration
  logic [COL_BITS-1:0] width_q;
  logic [ROW_BITS-1:0] height_q;
  logic                radius_q;
  logic                mode_q;

  // raster position of the next request
  logic [COL_BITS-1:0] col_q, col_d;
  logic [ROW_BITS-1:0] row_q, row_d;

  // pixel stage
  logic           s1_valid_q, s1_valid_d;
  pix_t           s1_pix_q;
  logic [AW-1:0]  s1_addr_q;
  logic           s1_produce_q;
  logic           s1_last_q;
  logic           fwd_q;
  logic [LW-1:0]  fwd_data_q;

  // output register
  logic out_valid_q, out_valid_d;
  pix_t out_pixel_q;
  logic out_last_q;

  logic                accept;
  logic                s1_fire;
  logic                r2;
  logic [COL_BITS-1:0] w_eff;
  logic [COL_BITS-1:0] two_r;
  logic [COL_BITS-1:0] ci_col;
  logic [AW-1:0]       ci;
  logic                col_wrap;
  logic                row_wrap;
  logic                produce;
  logic                last;

  logic [LW-1:0]                     ram_rdata;
  logic [LINES-1:0][PIXEL_BITS-1:0]  lines_rd;
  logic [LINES-1:0][PIXEL_BITS-1:0]  lines_wr;
  logic [WIN-1:0][PIXEL_BITS-1:0]    newcol;
  cmf_ctrl_t                         win_ctrl;
  pix_t                              win_result;

  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign accept     = in_valid_i && !in_stall_o;

  assign r2     = radius_q && (MAX_RADIUS >= 2);
  assign two_r  = r2 ? 11'd4 : 11'd2;
  assign w_eff  = (width_q > WIDTH_CAP) ? WIDTH_CAP : width_q;
  assign ci_col = (col_q > ADDR_CAP) ? ADDR_CAP : col_q;
  assign ci     = AW'(ci_col);

  assign col_wrap = ({1'b0, col_q} + 12'd1) >= {1'b0, w_eff};
  assign row_wrap = ({1'b0, row_q} + 17'd1) >= {1'b0, height_q};
  assign produce  = (col_q < w_eff) && (row_q < height_q) &&
                    (row_q >= {5'd0, two_r}) && (col_q >= two_r);
  assign last     = (({1'b0, row_q} + 17'd1) == {1'b0, height_q}) &&
                    (({1'b0, col_q} + 12'd1) == {1'b0, w_eff});

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + 16'd1;
      end else begin
        col_d = col_q + 11'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      radius_q <= 1'b0;
      mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cmf_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:   width_q  <= cfg_data_i[COL_BITS-1:0];
        REG_IMAGE_HEIGHT:  height_q <= cfg_data_i[ROW_BITS-1:0];
        REG_RADIUS_SELECT: radius_q <= cfg_data_i[0];
        REG_FILTER_MODE:   mode_q   <= cfg_data_i[0];
      endcase
    end
  end

  // line store column: read at request, shifted up and written back at fire
  cmf_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_fire),
    .waddr_i(s1_addr_q),
    .wdata_i(lines_wr),
    .re_i   (accept),
    .raddr_i(ci),
    .rdata_o(ram_rdata)
  );

  // same column read while it is being written: take the fresh data
  assign lines_rd = fwd_q ? fwd_data_q : ram_rdata;

  always_comb begin
    for (int y = 0; y < LINES - 1; y++) begin
      lines_wr[y] = lines_rd[y+1];
    end
    lines_wr[LINES-1] = s1_pix_q;
    for (int y = 0; y < LINES; y++) begin
      newcol[y] = lines_rd[y];
    end
    newcol[WIN-1] = s1_pix_q;
  end

  assign win_ctrl.shift    = s1_fire;
  assign win_ctrl.radius2  = r2;
  assign win_ctrl.take_max = mode_q;

  cmf_window #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_window (
    .clk_i   (clk_i),
    .ctrl_i  (win_ctrl),
    .newcol_i(newcol),
    .result_o(win_result)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    if (accept) begin
      s1_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (s1_fire) begin
      out_valid_d = s1_produce_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q     <= pixel_value_i;
      s1_addr_q    <= ci;
      s1_produce_q <= produce;
      s1_last_q    <= last;
      fwd_q        <= s1_fire && (s1_addr_q == ci);
      fwd_data_q   <= lines_wr;
    end
    if (s1_fire && s1_produce_q) begin
      out_pixel_q <= win_result;
      out_last_q  <= s1_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_pixel_o = out_pixel_q;
  assign frame_last_o     = out_last_q;

endmodule

`default_nettype wire

### design/cmf_checker.sv
`default_nettype none

module cmf_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              cfg_we_i,
  input wire logic [cmf_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input wire logic [cmf_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire cmf_pkg::pix_t                     pixel_value_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire cmf_pkg::pix_t                     filtered_pixel_o,
  input wire logic                              frame_last_o
);

  import cmf_pkg::*;

  logic unused_inputs;
  assign unused_inputs = cfg_we_i ^ (^cfg_index_i) ^ (^cfg_data_i) ^ (^pixel_value_i);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(filtered_pixel_o) &&
                                  $stable(frame_last_o))
    else $error("output changed while stalled");

  // the input waits only when the output side is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

  // a new result needs a request accepted earlier or a pixel held at the stalled input
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2) || $past(in_stall_o, 2))
    else $error("result without request");

endmodule

bind cross_morphology_filter_core cmf_checker u_cmf_checker (.*);

`default_nettype wire

### sim/tb_cross_morphology_filter_core.sv
`default_nettype none

module tb_cross_morphology_filter_core;
  import cmf_pkg::*;

  localparam int LINES       = 2 * CMF_MAX_RADIUS;
  localparam int TAPS        = LINES + 1;
  localparam int SETTLE      = 4;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_PIXELS = 950;

  typedef logic [CFG_DATA_BITS-1:0] cfg_word_t;

  typedef struct packed {
    pix_t px;
    logic last;
  } cross_result_t;

  typedef enum int {
    PAT_RANDOM,
    PAT_DARK,
    PAT_BRIGHT,
    PAT_EXTREMES,
    PAT_NARROW
  } pattern_e;

  class morph_scoreboard;
    int unsigned width_reg;
    int unsigned height_reg;
    bit radius2;
    bit take_max;
    pix_t rows [LINES][CMF_MAX_WIDTH];
    pix_t win [TAPS][TAPS];
    int unsigned next_col;
    int unsigned next_row;
    cross_result_t filtered_due[$];
    int errors;

    function new();
      width_reg  = 32'(WIDTH_RESET);
      height_reg = 32'(HEIGHT_RESET);
      radius2    = 1'b0;
      take_max   = 1'b0;
      next_col   = 0;
      next_row   = 0;
      errors     = 0;
      foreach (rows[y, x]) rows[y][x] = '0;
      foreach (win[y, x]) win[y][x] = '0;
    endfunction

    function void set_reg(cmf_reg_e idx, cfg_word_t data);
      case (idx)
        REG_IMAGE_WIDTH:   width_reg = 32'(data[COL_BITS-1:0]);
        REG_IMAGE_HEIGHT:  height_reg = 32'(data[ROW_BITS-1:0]);
        REG_RADIUS_SELECT: radius2 = data[0];
        REG_FILTER_MODE:   take_max = data[0];
        default: ;
      endcase
    endfunction

    function pix_t extreme(pix_t acc, pix_t v);
      if (take_max) return (v > acc) ? v : acc;
      return (v < acc) ? v : acc;
    endfunction

    // advance the line store and window by one pixel, queue the filtered value if due
    function void take_pixel(pix_t v);
      int unsigned w, r, ci, c;
      pix_t fresh [TAPS];
      pix_t acc;
      cross_result_t res;
      w  = (width_reg > CMF_MAX_WIDTH) ? CMF_MAX_WIDTH : width_reg;
      r  = radius2 ? 2 : 1;
      ci = (next_col < CMF_MAX_WIDTH) ? next_col : CMF_MAX_WIDTH - 1;
      for (int y = 0; y < LINES; y++) fresh[y] = rows[y][ci];
      fresh[LINES] = v;
      for (int y = 0; y + 1 < LINES; y++) rows[y][ci] = rows[y + 1][ci];
      rows[LINES - 1][ci] = v;
      for (int y = 0; y < TAPS; y++) begin
        for (int x = 0; x + 1 < TAPS; x++) win[y][x] = win[y][x + 1];
        win[y][TAPS - 1] = fresh[y];
      end
      if (next_col < w && next_row < height_reg && next_row >= 2 * r && next_col >= 2 * r) begin
        c   = TAPS - 1 - r;
        acc = win[c][c];
        for (int k = TAPS - 1 - 2 * r; k < TAPS; k++) begin
          acc = extreme(acc, win[k][c]);
          acc = extreme(acc, win[c][k]);
        end
        res.px   = acc;
        res.last = (next_row + 1 == height_reg) && (next_col + 1 == w);
        filtered_due.push_back(res);
      end
      // raster counters, a counter past its limit wraps here
      if (next_col + 1 >= w) begin
        next_col = 0;
        next_row = (next_row + 1 >= height_reg) ? 0 : next_row + 1;
      end else begin
        next_col = next_col + 1;
      end
    endfunction

    function void check_result(pix_t px, logic last);
      cross_result_t want;
      if (filtered_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: pixel %0d last %0b", px, last);
        return;
      end
      want = filtered_due.pop_front();
      if (px !== want.px || last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: pixel exp %0d got %0d, last exp %0b got %0b",
                   want.px, px, want.last, last);
      end
    endfunction

    function int pending();
      return filtered_due.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = REG_IMAGE_WIDTH;
  cfg_word_t                cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  pix_t                     pixel_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  pix_t                     filtered_pixel_o;
  logic                     frame_last_o;

  morph_scoreboard sb = new();
  int unsigned pixels_sent = 0;
  int quiet = 0;
  int stall_left = 0;
  int free_left = 0;

  cross_morphology_filter_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pixel_value_i    (pixel_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_pixel_o (filtered_pixel_o),
    .frame_last_o     (frame_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // consumer back-pressure: short free runs, sometimes long clean stretches
  always @(posedge clk_i) begin
    int roll;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (free_left > 0) begin
      free_left <= free_left - 1;
      out_stall_i <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      free_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 6);
      if (roll < 50) stall_left <= 0;
      else if (roll < 90) stall_left <= $urandom_range(1, 3);
      else stall_left <= $urandom_range(8, 40);
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i)
      sb.check_result(filtered_pixel_o, frame_last_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o === 1'b1 && !out_stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
  end

  initial begin
    wait (quiet >= QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic pix_t make_pixel(pattern_e pat);
    case (pat)
      PAT_DARK:     return '0;
      PAT_BRIGHT:   return '1;
      PAT_EXTREMES: return $urandom_range(0, 1) ? '1 : '0;
      PAT_NARROW:   return pix_t'(100 + $urandom_range(0, 3));
      default:      return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // one pixel request; valid stays up across back-to-back requests
  task automatic send_pixel(input pix_t v, input bit no_gap);
    int gap, roll;
    roll = $urandom_range(0, 99);
    if (no_gap || roll < 60) gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_pixel(v);
    pixels_sent++;
  endtask

  task automatic send_frame(input int unsigned count, input pattern_e pat);
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    repeat (count) send_pixel(make_pixel(pat), burst);
  endtask

  task automatic align_to_frame();
    while (sb.next_col != 0 || sb.next_row != 0) send_pixel(make_pixel(PAT_RANDOM), 1'b0);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    // pixels that give no result may still be in flight
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cmf_reg_e idx, input cfg_word_t data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic poke(input cmf_reg_e idx, input cfg_word_t data);
    wait_idle();
    write_reg(idx, data);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input bit r, input bit m);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, cfg_word_t'(w));
    write_reg(REG_IMAGE_HEIGHT, cfg_word_t'(h));
    write_reg(REG_RADIUS_SELECT, cfg_word_t'(r));
    write_reg(REG_FILTER_MODE, cfg_word_t'(m));
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned w, h, first;
    int roll;
    cmf_reg_e idx;
    cfg_word_t data;
    pattern_e pat;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // width above capacity, then cut under the current column
    configure(2047, 4, 1'b0, 1'b0);
    send_frame(40, PAT_RANDOM);
    poke(REG_IMAGE_WIDTH, 8);
    align_to_frame();

    // smallest frames for both radii and modes
    configure(3, 3, 1'b0, 1'b0);
    send_frame(9, PAT_RANDOM);
    configure(3, 3, 1'b0, 1'b1);
    send_frame(9, PAT_EXTREMES);
    configure(5, 5, 1'b1, 1'b0);
    send_frame(25, PAT_RANDOM);
    configure(5, 5, 1'b1, 1'b1);
    send_frame(25, PAT_NARROW);
    configure(6, 5, 1'b0, 1'b0);
    send_frame(30, PAT_BRIGHT);
    configure(6, 5, 1'b0, 1'b1);
    send_frame(30, PAT_DARK);

    // frame too small for the cross, then zero and one sizes
    configure(4, 6, 1'b1, 1'b1);
    send_frame(24, PAT_RANDOM);
    configure(7, 4, 1'b1, 1'b0);
    send_frame(28, PAT_RANDOM);
    configure(0, 3, 1'b0, 1'b0);
    send_frame(3, PAT_RANDOM);
    configure(1, 1, 1'b0, 1'b1);
    send_frame(4, PAT_RANDOM);
    configure(3, 0, 1'b0, 1'b0);
    send_frame(3, PAT_RANDOM);
    configure(2, 2, 1'b0, 1'b0);
    send_frame(4, PAT_RANDOM);

    // largest height, then cut below the current row mid-frame
    configure(7, 65535, 1'b0, 1'b0);
    send_frame(35, PAT_RANDOM);
    poke(REG_IMAGE_HEIGHT, 4);
    send_frame(7, PAT_RANDOM);
    send_frame(28, PAT_RANDOM);
    // width shrunk under the current column
    configure(20, 6, 1'b0, 1'b1);
    send_frame(52, PAT_RANDOM);
    poke(REG_IMAGE_WIDTH, 8);
    align_to_frame();
    // radius and mode changed mid-frame
    configure(9, 8, 1'b0, 1'b0);
    send_frame(40, PAT_RANDOM);
    wait_idle();
    write_reg(REG_RADIUS_SELECT, 1);
    write_reg(REG_FILTER_MODE, 1);
    cfg_we_i <= 1'b0;
    align_to_frame();

    first = pixels_sent;
    while (pixels_sent - first < RANDOM_PIXELS) begin
      roll = $urandom_range(0, 99);
      pat  = ($urandom_range(0, 3) != 0) ? PAT_RANDOM : pattern_e'($urandom_range(0, 4));
      if (roll < 80) begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(3, 20);
        h = $urandom_range(3, 9);
        configure(w, h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_frame(w * h, pat);
      end else if (roll < 90) begin
        configure($urandom_range(0, 4), $urandom_range(0, 4),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_frame($urandom_range(1, 30), pat);
        align_to_frame();
      end else begin
        // broken frame: a register changes partway through
        w = $urandom_range(3, 16);
        h = $urandom_range(3, 8);
        configure(w, h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_frame($urandom_range(1, w * h - 1), pat);
        idx  = cmf_reg_e'($urandom_range(0, 3));
        data = cfg_word_t'($urandom);
        if (idx == REG_IMAGE_WIDTH) data[COL_BITS-1:0] = COL_BITS'($urandom_range(0, 24));
        else if (idx == REG_IMAGE_HEIGHT) data = cfg_word_t'($urandom_range(0, 12));
        poke(idx, data);
        send_frame($urandom_range(0, 10), PAT_RANDOM);
        align_to_frame();
      end
    end

    wait_idle();
    repeat (2 * SETTLE) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
